### rtl/tsb_pkg.sv
`timescale 1ns / 1ps

package tsb_pkg;

    // Texture store and coordinate geometry
    localparam int TEXEL_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int MAX_DIM     = 256;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int FRAC_W      = 16;
    localparam int SCALED_W    = COORD_W + FRAC_W;

    // Blend arithmetic
    localparam int WEIGHT_BITS = 8;
    localparam int WGT_W       = WEIGHT_BITS + 1;
    localparam int PROD_W      = 2 * WEIGHT_BITS + 1;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PTERM_W     = CH_W + PROD_W;
    localparam int ACC_W       = PTERM_W + 2;

    // Queue depths
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;

    // Codes
    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_SAMPLE    = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd2;

    // Item passed from the front end to the back end
    typedef struct packed {
        logic                action;
        logic [ADDR_W-1:0]   texel_index;
        logic [COLOR_W-1:0]  texel_color;
        logic [SCALED_W-1:0] su;
        logic [SCALED_W-1:0] sv;
    } mid_item_t;

    // Finished sample waiting at the output
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            edge_fallback;
    } result_t;

    // A size of zero acts as one, a size above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

endpackage

### rtl/tsb_fifo.sv
`timescale 1ns / 1ps

module tsb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slots_reg[rd_ptr_reg];

    // Pointer and occupancy update with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= din;
    end

endmodule

### rtl/tsb_front.sv
`timescale 1ns / 1ps

module tsb_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [tsb_pkg::DIM_W-1:0]       wc,
    input  logic [tsb_pkg::DIM_W-1:0]       hc,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [15:0]                     texel_index,
    input  logic [23:0]                     texel_color,
    input  logic signed [31:0]              u_coord,
    input  logic signed [31:0]              v_coord,
    input  logic                            item_pop,
    output tsb_pkg::mid_item_t              item,
    output logic                            item_valid
);

    import tsb_pkg::*;

    logic [DIM_W+FRAC_W-1:0] prod_u;
    logic [DIM_W+FRAC_W-1:0] prod_v;
    mid_item_t               in_item;
    logic                    mid_empty;

    // Scaling and wrapping collapse to the texture size times the low
    // 16 bits of the coordinate, which already lies in [0, size).
    assign prod_u = wc * u_coord[FRAC_W-1:0];
    assign prod_v = hc * v_coord[FRAC_W-1:0];

    always_comb
    begin
        in_item.action      = action;
        in_item.texel_index = texel_index[ADDR_W-1:0];
        in_item.texel_color = texel_color;
        in_item.su          = prod_u[SCALED_W-1:0];
        in_item.sv          = prod_v[SCALED_W-1:0];
    end

    // Short queue that decouples the front end from the back end
    tsb_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (item_pop),
        .dout  (item),
        .empty (mid_empty)
    );

    assign item_valid = !mid_empty;

endmodule

### rtl/tsb_back.sv
`timescale 1ns / 1ps

module tsb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tsb_pkg::DIM_W-1:0] wc,
    input  logic [tsb_pkg::DIM_W-1:0] hc,
    input  logic                      filter_mode,
    input  tsb_pkg::mid_item_t        item,
    input  logic                      item_valid,
    output logic                      item_pop,
    input  logic                      result_taken,
    output tsb_pkg::result_t          result,
    output logic                      result_push
);

    import tsb_pkg::*;

    localparam int RES_W = $clog2(OUT_DEPTH + 1);
    localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << WEIGHT_BITS);

    // Stage 0 decode
    logic [COORD_W-1:0]       x0, y0, x1_0, y1_0;
    logic [FRAC_W-1:0]        fu0, fv0;
    logic [DIM_W-1:0]         x_inc, y_inc;
    logic                     edge0;
    logic [COORD_W+DIM_W-1:0] yw_full, y1w_full;
    logic                     issue;
    logic [RES_W-1:0]         reserved_reg, reserved_next;

    // Stage 1
    logic                     s1_valid_reg, s1_write_reg, s1_near_reg, s1_edge_reg;
    logic [ADDR_W-1:0]        s1_waddr_reg, s1_yw_reg, s1_y1w_reg;
    logic [COLOR_W-1:0]       s1_color_reg;
    logic [COORD_W-1:0]       s1_x_reg, s1_x1_reg;
    logic [WEIGHT_BITS-1:0]   s1_fx_reg, s1_fy_reg;

    // Stage 2
    logic [WGT_W-1:0]         wx1, wx0, wy1, wy0;
    logic [2*WGT_W-1:0]       w_full [4];
    logic                     s2_valid_reg, s2_write_reg, s2_near_reg, s2_edge_reg;
    logic [ADDR_W-1:0]        s2_waddr_reg;
    logic [COLOR_W-1:0]       s2_color_reg;
    logic [ADDR_W-1:0]        s2_addr_reg [4];
    logic [PROD_W-1:0]        s2_wgt_reg [4];

    // Stage 3 (read data from the banks)
    logic                     s3_valid_reg, s3_near_reg, s3_edge_reg;
    logic [PROD_W-1:0]        s3_wgt_reg [4];
    logic [COLOR_W-1:0]       rdata_reg [4];

    // Stage 4
    logic                     s4_valid_reg, s4_near_reg, s4_edge_reg;
    logic [COLOR_W-1:0]       s4_c0_reg;
    logic [PTERM_W-1:0]       s4_term_reg [NUM_CH][4];
    logic [ACC_W-1:0]         acc [NUM_CH];
    logic [COLOR_W-1:0]       blend;
    logic [COLOR_W-1:0]       final_color;

    // Stage 0: neighbor coordinates, border test and row bases
    always_comb
    begin
        x0    = item.su[SCALED_W-1:FRAC_W];
        y0    = item.sv[SCALED_W-1:FRAC_W];
        fu0   = item.su[FRAC_W-1:0];
        fv0   = item.sv[FRAC_W-1:0];
        x_inc = DIM_W'(x0) + DIM_W'(1);
        y_inc = DIM_W'(y0) + DIM_W'(1);
        x1_0  = (x_inc >= wc) ? '0 : x_inc[COORD_W-1:0];
        y1_0  = (y_inc >= hc) ? '0 : y_inc[COORD_W-1:0];
        edge0 = (x0 == '0) || (y0 == '0) ||
                ((DIM_W'(x0) == wc - DIM_W'(1)) && (fu0 != '0)) ||
                ((DIM_W'(y0) == hc - DIM_W'(1)) && (fv0 != '0));
        yw_full  = y0 * wc;
        y1w_full = y1_0 * wc;
    end

    // A sample leaves the queue only when its result has a slot reserved; writes need no slot.
    assign issue    = item_valid &&
                      ((item.action == ACT_WRITE) || (reserved_reg < RES_W'(OUT_DEPTH)));
    assign item_pop = issue;

    always_comb
    begin
        reserved_next = reserved_reg;
        if (issue && (item.action == ACT_SAMPLE) && !result_taken)
            reserved_next = reserved_reg + RES_W'(1);
        else if (!(issue && (item.action == ACT_SAMPLE)) && result_taken)
            reserved_next = reserved_reg - RES_W'(1);
    end

    // Stage 2 weights
    always_comb
    begin
        wx1 = WGT_W'(s1_fx_reg);
        wy1 = WGT_W'(s1_fy_reg);
        wx0 = W_ONE - wx1;
        wy0 = W_ONE - wy1;
        w_full[0] = wx0 * wy0;
        w_full[1] = wx1 * wy0;
        w_full[2] = wx0 * wy1;
        w_full[3] = wx1 * wy1;
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && !s2_write_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        s1_write_reg <= (item.action == ACT_WRITE);
        s1_near_reg  <= (filter_mode == MODE_NEAREST) || edge0;
        s1_edge_reg  <= (filter_mode == MODE_BILINEAR) && edge0;
        s1_waddr_reg <= item.texel_index;
        s1_color_reg <= item.texel_color;
        s1_x_reg     <= x0;
        s1_x1_reg    <= x1_0;
        s1_fx_reg    <= fu0[FRAC_W-1 -: WEIGHT_BITS];
        s1_fy_reg    <= fv0[FRAC_W-1 -: WEIGHT_BITS];
        s1_yw_reg    <= yw_full[ADDR_W-1:0];
        s1_y1w_reg   <= y1w_full[ADDR_W-1:0];

        s2_write_reg   <= s1_write_reg;
        s2_near_reg    <= s1_near_reg;
        s2_edge_reg    <= s1_edge_reg;
        s2_waddr_reg   <= s1_waddr_reg;
        s2_color_reg   <= s1_color_reg;
        s2_addr_reg[0] <= s1_yw_reg + ADDR_W'(s1_x_reg);
        s2_addr_reg[1] <= s1_yw_reg + ADDR_W'(s1_x1_reg);
        s2_addr_reg[2] <= s1_y1w_reg + ADDR_W'(s1_x_reg);
        s2_addr_reg[3] <= s1_y1w_reg + ADDR_W'(s1_x1_reg);
        for (int k = 0; k < 4; k++)
            s2_wgt_reg[k] <= w_full[k][PROD_W-1:0];

        s3_near_reg <= s2_near_reg;
        s3_edge_reg <= s2_edge_reg;
        for (int k = 0; k < 4; k++)
            s3_wgt_reg[k] <= s2_wgt_reg[k];

        s4_near_reg <= s3_near_reg;
        s4_edge_reg <= s3_edge_reg;
        s4_c0_reg   <= rdata_reg[0];
        for (int ch = 0; ch < NUM_CH; ch++)
            for (int k = 0; k < 4; k++)
                s4_term_reg[ch][k] <= rdata_reg[k][ch*CH_W +: CH_W] * s3_wgt_reg[k];
    end

    // Four replicated texel banks: each write goes to all, each serves one neighbor.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [COLOR_W-1:0] bank_mem [TEXEL_DEPTH];

        always_ff @(posedge clk)
        begin
            if (s2_valid_reg && s2_write_reg)
                bank_mem[s2_waddr_reg] <= s2_color_reg;
            rdata_reg[b] <= bank_mem[s2_addr_reg[b]];
        end
    end

    // Stage 4: sum the weighted corners and keep the integer part; nearest and border samples take corner 0
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            acc[ch] = ACC_W'(s4_term_reg[ch][0]) + ACC_W'(s4_term_reg[ch][1]) +
                      ACC_W'(s4_term_reg[ch][2]) + ACC_W'(s4_term_reg[ch][3]);
            blend[ch*CH_W +: CH_W] = acc[ch][2*WEIGHT_BITS +: CH_W];
        end
        final_color = s4_near_reg ? s4_c0_reg : blend;
    end

    assign result_push          = s4_valid_reg;
    assign result.red           = final_color[3*CH_W-1:2*CH_W];
    assign result.green         = final_color[2*CH_W-1:CH_W];
    assign result.blue          = final_color[CH_W-1:0];
    assign result.edge_fallback = s4_edge_reg;

endmodule

### rtl/texture_sampler_bilinear.sv
`timescale 1ns / 1ps

// Bilinear texture sampler. Writes load one 24-bit texel into a 64K-entry
// store; samples take Q16.16 coordinates and return one RGB result each,
// filtered bilinearly or by nearest texel as filter_mode selects. The block
// takes one transaction per clock while full is low: a front end scales
// the coordinates and queues the item, and a five-stage back end reads the
// four neighbors in parallel from four replicated texel banks and blends
// them. A sample passes the front-end queue and the back-end stages on its
// way to the output queue, which holds eight results; the back end reserves
// a slot before each sample, so a stalled reader fills the queues and then
// raises full. Writes take effect in order with samples. Configure the size
// and mode only while no transaction is in flight.
module texture_sampler_bilinear (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              action,
    input  logic [15:0]                       texel_index,
    input  logic [23:0]                       texel_color,
    input  logic signed [31:0]                u_coord,
    input  logic signed [31:0]                v_coord,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              edge_fallback,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tsb_pkg::*;

    logic [DIM_W-1:0] tex_width_reg;
    logic [DIM_W-1:0] tex_height_reg;
    logic             filter_mode_reg;
    logic [DIM_W-1:0] wc;
    logic [DIM_W-1:0] hc;
    mid_item_t        item;
    logic             item_valid;
    logic             item_pop;
    result_t          back_result;
    logic             result_push;
    result_t          out_result;
    logic             result_taken;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg   <= DIM_W'(256);
            tex_height_reg  <= DIM_W'(256);
            filter_mode_reg <= MODE_BILINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEX_WIDTH:   tex_width_reg   <= cfg_data[DIM_W-1:0];
                REG_TEX_HEIGHT:  tex_height_reg  <= cfg_data[DIM_W-1:0];
                REG_FILTER_MODE: filter_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign wc = clamp_dim(tex_width_reg);
    assign hc = clamp_dim(tex_height_reg);

    // Front end: scaling and the decoupling queue
    tsb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .wc          (wc),
        .hc          (hc),
        .push        (push),
        .full        (full),
        .action      (action),
        .texel_index (texel_index),
        .texel_color (texel_color),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .item_pop    (item_pop),
        .item        (item),
        .item_valid  (item_valid)
    );

    // Back end: texel banks and blend pipeline
    tsb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wc           (wc),
        .hc           (hc),
        .filter_mode  (filter_mode_reg),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .result_taken (result_taken),
        .result       (back_result),
        .result_push  (result_push)
    );

    // Output queue; slots are reserved upstream so it never overflows.
    tsb_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .din   (back_result),
        .full  (),
        .pop   (pop),
        .dout  (out_result),
        .empty (empty)
    );

    assign result_taken  = pop && !empty;
    assign red           = out_result.red;
    assign green         = out_result.green;
    assign blue          = out_result.blue;
    assign edge_fallback = out_result.edge_fallback;

endmodule

### sim/sampler_checker.sv
`timescale 1ns / 1ps

module sampler_checker
    import tsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  action,
    input  logic [15:0]           texel_index,
    input  logic [23:0]           texel_color,
    input  logic signed [31:0]    u_coord,
    input  logic signed [31:0]    v_coord,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic                  edge_fallback,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    // Shadow copy of the texture and the size and mode registers.
    logic [COLOR_W-1:0] shadow_texels [0:TEXEL_DEPTH-1];
    logic [DIM_W-1:0]   shadow_width;
    logic [DIM_W-1:0]   shadow_height;
    logic               shadow_mode;
    result_t            expected_colors [$];

    // Scale a Q16.16 coordinate by the size and wrap it into [0, dim) as Q.16.
    function automatic logic [31:0] wrap_coord(logic signed [31:0] c, int unsigned dim);
        longint s;
        longint p;
        longint m;
        s = longint'(c) * longint'(dim);
        p = longint'(dim) << 16;
        m = s % p;
        if (m < 0)
            m += p;
        return m[31:0];
    endfunction

    function automatic int unsigned limit_dim(logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return 32'(d);
    endfunction

    function automatic logic [COLOR_W-1:0] texel_at(int unsigned x, int unsigned y,
                                                    int unsigned w);
        return shadow_texels[(y * w + x) % TEXEL_DEPTH];
    endfunction

    // Work out the filtered color for one sample.
    function automatic result_t filter_sample(logic signed [31:0] u, logic signed [31:0] v);
        int unsigned w, h, x, y, x1, y1, fx, fy, acc;
        logic [31:0] su, sv;
        logic [COLOR_W-1:0] c0, c1, c2, c3, mix;
        result_t r;
        w = limit_dim(shadow_width);
        h = limit_dim(shadow_height);
        su = wrap_coord(u, w);
        sv = wrap_coord(v, h);
        x = su >> 16;
        y = sv >> 16;
        r.edge_fallback = 1'b0;
        if (shadow_mode == MODE_NEAREST)
        begin
            mix = texel_at(x, y, w);
        end
        else if (su < 32'h10000 || sv < 32'h10000 ||
                 su > ((w - 1) << 16) || sv > ((h - 1) << 16))
        begin
            // Border: fall back to the nearest texel.
            mix = texel_at(x, y, w);
            r.edge_fallback = 1'b1;
        end
        else
        begin
            fx = su[15:16-WEIGHT_BITS];
            fy = sv[15:16-WEIGHT_BITS];
            x1 = (x + 1 >= w) ? 0 : x + 1;
            y1 = (y + 1 >= h) ? 0 : y + 1;
            c0 = texel_at(x, y, w);
            c1 = texel_at(x1, y, w);
            c2 = texel_at(x, y1, w);
            c3 = texel_at(x1, y1, w);
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                acc = c0[ch*8 +: 8] * (256 - fx) * (256 - fy)
                    + c1[ch*8 +: 8] * fx * (256 - fy)
                    + c2[ch*8 +: 8] * (256 - fx) * fy
                    + c3[ch*8 +: 8] * fx * fy;
                mix[ch*8 +: 8] = 8'(acc >> (2 * WEIGHT_BITS));
            end
        end
        r.red   = mix[23:16];
        r.green = mix[15:8];
        r.blue  = mix[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Follow every transaction on the three channels.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            shadow_width  <= DIM_W'(256);
            shadow_height <= DIM_W'(256);
            shadow_mode   <= MODE_BILINEAR;
            expected_colors.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TEX_WIDTH:   shadow_width  <= cfg_data;
                    REG_TEX_HEIGHT:  shadow_height <= cfg_data;
                    REG_FILTER_MODE: shadow_mode   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                if (action == ACT_WRITE)
                    shadow_texels[texel_index] = texel_color;
                else
                    expected_colors.push_back(filter_sample(u_coord, v_coord));
            end
            if (pop && !empty)
            begin
                if (expected_colors.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'({red, green, blue}), 0);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (red != want.red)
                        report_mismatch("red", red, want.red);
                    if (green != want.green)
                        report_mismatch("green", green, want.green);
                    if (blue != want.blue)
                        report_mismatch("blue", blue, want.blue);
                    if (edge_fallback != want.edge_fallback)
                        report_mismatch("edge_fallback", edge_fallback, want.edge_fallback);
                end
            end
            pending = expected_colors.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tsb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  action;
    logic [15:0]           texel_index;
    logic [23:0]           texel_color;
    logic signed [31:0]    u_coord;
    logic signed [31:0]    v_coord;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  edge_fallback;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    // Texels the stimulus has loaded, so no sample reads an unwritten one.
    bit                    loaded [0:TEXEL_DEPTH-1];
    int unsigned           cur_width;
    int unsigned           cur_height;
    int                    burst_left;
    int                    idle_cycles = 0;
    int                    pop_style = 0;
    int                    sent_items;

    texture_sampler_bilinear DUT (.*);

    sampler_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stall pattern: the style changes at random times.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            pop_style <= $urandom_range(0, 3);
        case (pop_style)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 9) == 0);
            default: pop <= ($urandom_range(0, 39) < 38);
        endcase
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned texel_coord(logic signed [31:0] c, int unsigned dim);
        longint m;
        m = (longint'(c) * longint'(dim)) % (longint'(dim) << 16);
        if (m < 0)
            m += longint'(dim) << 16;
        return 32'(m >> 16);
    endfunction

    task automatic send_item(logic act, logic [15:0] idx, logic [23:0] col,
                             logic [31:0] u, logic [31:0] v);
        // Sender bursts with random gaps between them.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        action      <= act;
        texel_index <= idx;
        texel_color <= col;
        u_coord     <= u;
        v_coord     <= v;
        if (act == ACT_WRITE)
            loaded[idx] = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic load_if_needed(int unsigned x, int unsigned y);
        int unsigned a;
        a = (y * cur_width + x) % TEXEL_DEPTH;
        if (!loaded[a])
            send_item(ACT_WRITE, 16'(a), 24'($urandom), $urandom, $urandom);
    endtask

    // One sample, preceded by writes for any neighbor texel not yet loaded.
    task automatic sample_at(logic [31:0] u, logic [31:0] v);
        int unsigned x, y, x1, y1;
        x  = texel_coord(u, cur_width);
        y  = texel_coord(v, cur_height);
        x1 = (x + 1 >= cur_width) ? 0 : x + 1;
        y1 = (y + 1 >= cur_height) ? 0 : y + 1;
        load_if_needed(x, y);
        load_if_needed(x1, y);
        load_if_needed(x, y1);
        load_if_needed(x1, y1);
        send_item(ACT_SAMPLE, 16'($urandom), 24'($urandom), u, v);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Let everything in flight finish before touching the registers.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_texture(int unsigned w, int unsigned h, logic mode);
        wait_idle();
        write_reg(REG_TEX_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_TEX_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_FILTER_MODE, CFG_DATA_W'(mode));
        cur_width  = (w == 0) ? 1 : (w > MAX_DIM) ? MAX_DIM : w;
        cur_height = (h == 0) ? 1 : (h > MAX_DIM) ? MAX_DIM : h;
    endtask

    // Send about count items, the texel loads before each sample included.
    task automatic random_items(int count);
        int unsigned span;
        int stop;
        stop = sent_items + count;
        while (sent_items < stop)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                send_item(ACT_WRITE, 16'($urandom), 24'($urandom), $urandom, $urandom);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                sample_at($urandom, $urandom);
            end
            else
            begin
                // Coordinates around the unit square, where wrapping and borders matter.
                span = 3 << 16;
                sample_at($urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 2 * span) - span);
            end
        end
    endtask

    initial
    begin
        logic [31:0] corner_coords [6];
        corner_coords = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                          32'hFFFFFFFF, 32'h00008000};
        rst_n       = 1'b0;
        push        = 1'b0;
        action      = ACT_WRITE;
        texel_index = '0;
        texel_color = '0;
        u_coord     = '0;
        v_coord     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_TEX_WIDTH;
        cfg_data    = '0;
        burst_left  = 0;
        sent_items  = 0;
        cur_width   = 256;
        cur_height  = 256;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: color and index extremes, then corner coordinates at reset size and at other sizes.
        send_item(ACT_WRITE, 16'h0000, 24'h000000, '0, '0);
        send_item(ACT_WRITE, 16'hFFFF, 24'hFFFFFF, '1, '1);
        sample_at(32'h00808000, 32'h00404000);
        foreach (corner_coords[i])
            sample_at(corner_coords[i], corner_coords[5 - i]);
        set_texture(1, 1, MODE_BILINEAR);
        foreach (corner_coords[i])
            sample_at(corner_coords[i], corner_coords[i]);
        set_texture(0, 300, MODE_NEAREST);
        foreach (corner_coords[i])
            sample_at(corner_coords[i], corner_coords[5 - i]);
        // An unknown register index is ignored.
        wait_idle();
        write_reg(REG_UNKNOWN, '1);

        // Random phases across sizes and modes, the extremes among them.
        set_texture(256, 256, MODE_BILINEAR);
        random_items(140);
        set_texture(511, 1, MODE_BILINEAR);
        random_items(120);
        set_texture(1, 256, MODE_NEAREST);
        random_items(120);
        set_texture(256, 256, MODE_NEAREST);
        random_items(120);
        set_texture(7, 5, MODE_BILINEAR);
        random_items(140);
        set_texture(3, 200, MODE_BILINEAR);
        random_items(120);
        set_texture(2, 2, MODE_BILINEAR);
        random_items(120);
        for (int p = 0; p < 4; p++)
        begin
            set_texture($urandom_range(0, 511), $urandom_range(0, 511),
                        1'($urandom_range(0, 1)));
            random_items(100);
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
